@@ design/ltf_pkg.sv @@
// shared widths, constants and register codes for the langevin force block
// no dependencies
package ltf_pkg;

   // fixed point field widths
   localparam int FIX_W   = 32;               // q16.16 mass, velocity, force, gamma, scale
   localparam int FRAC_W  = 16;               // fraction bits of q16.16
   localparam int RAND_W  = 16;               // random fraction width
   localparam int GM_W    = 48;               // gamma times mass, q16.16 below 2^48
   localparam int SCALE_W = 33;               // noise scale after optional sqrt(3) boost
   localparam int CMAG_W  = 16;               // magnitude of centered random, up to one half
   localparam int A_W     = 33;               // scale times centered random
   localparam int FR_W    = 44;               // signed friction term, magnitude clamped to 2^42
   localparam int FRMAG_W = 43;
   localparam int NZ_W    = 41;               // noise term magnitude
   localparam int SUM_W   = 45;               // exact signed sum before saturation

   // rounding and boost constants
   localparam logic [FRAC_W:0] HALF_Q16  = 17'd32768;
   localparam logic [16:0]     SQRT3_Q16 = 17'd113512;
   localparam logic [63:0]     FRICTION_LIMIT = 64'd1 << 42;

   // square root pipeline: radicand is mass shifted up by the fraction width
   localparam int RAD_W       = FIX_W + FRAC_W;
   localparam int ROOT_W      = RAD_W / 2;
   localparam int REM_W       = ROOT_W + 2;
   localparam int SQRT_STEPS  = 2;            // result bits per pipeline stage
   localparam int SQRT_STAGES = ROOT_W / SQRT_STEPS;

   // lane timing: friction is ready at stage 3 and waits for the root
   localparam int LANE_DELAY = SQRT_STAGES - 3;
   localparam int PIPE_DEPTH = SQRT_STAGES + 2;

   // configuration register indexes
   localparam int CSR_IDX_W = 2;
   typedef enum logic [CSR_IDX_W-1:0] {
      REG_FRICTION_GAMMA = 2'd0,
      REG_NOISE_SCALE    = 2'd1,
      REG_HEAT_BOOST     = 2'd2
   } csr_reg_type;

   // one result: three saturated force components
   typedef struct packed {
      logic [FIX_W-1:0] x;
      logic [FIX_W-1:0] y;
      logic [FIX_W-1:0] z;
   } force_vec_type;

endpackage

@@ design/langevin_thermostat_force.sv @@
// Langevin thermostat force update. Throughput is one particle per cycle while req_stall
// is low; the 12-stage mass square root pipeline sets the depth, with three axis lanes
// working side by side behind it.
// A stalled output fills a one-entry skid register, after which req_stall rises.
// Synchronous reset empties the pipeline and clears gamma, noise scale and boost to zero.
// Depends on ltf_pkg, ltf_isqrt, ltf_lane and ltf_merge.
module langevin_thermostat_force (
   input  logic                          clock,
   input  logic                          reset,
   // configuration
   input  logic                          csr_wr_en,
   input  logic [ltf_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ltf_pkg::FIX_W-1:0]     csr_wdata,
   // particle input
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [ltf_pkg::FIX_W-1:0]     req_mass,
   input  logic [ltf_pkg::FIX_W-1:0]     req_vel_x,
   input  logic [ltf_pkg::FIX_W-1:0]     req_vel_y,
   input  logic [ltf_pkg::FIX_W-1:0]     req_vel_z,
   input  logic [ltf_pkg::FIX_W-1:0]     req_force_x,
   input  logic [ltf_pkg::FIX_W-1:0]     req_force_y,
   input  logic [ltf_pkg::FIX_W-1:0]     req_force_z,
   input  logic [ltf_pkg::RAND_W-1:0]    req_rand_x,
   input  logic [ltf_pkg::RAND_W-1:0]    req_rand_y,
   input  logic [ltf_pkg::RAND_W-1:0]    req_rand_z,
   // force result
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [ltf_pkg::FIX_W-1:0]     rsp_new_force_x,
   output logic [ltf_pkg::FIX_W-1:0]     rsp_new_force_y,
   output logic [ltf_pkg::FIX_W-1:0]     rsp_new_force_z
);

   logic [ltf_pkg::FIX_W-1:0]      gamma_ff, noise_ff;
   logic                           boost_ff;
   logic [ltf_pkg::SCALE_W-1:0]    scale_ff, scale_in;
   logic [49:0]                    boost_prod;
   logic [63:0]                    gm_prod;
   logic [ltf_pkg::GM_W-1:0]       gm_ff, gm_in;
   logic [ltf_pkg::PIPE_DEPTH-1:0] vld_ff, vld_in;
   logic [ltf_pkg::ROOT_W-1:0]     sm;
   logic [ltf_pkg::SUM_W-1:0]      sum_x, sum_y, sum_z;
   logic                           adv, pipe_hold;
   ltf_pkg::force_vec_type         rsp_data;

   // whole pipeline moves unless the skid register is occupied
   assign adv       = ~pipe_hold;
   assign req_stall = pipe_hold;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         gamma_ff <= '0;
         noise_ff <= '0;
         boost_ff <= 1'b0;
      end else if (csr_wr_en) begin
         case (csr_index)
            ltf_pkg::REG_FRICTION_GAMMA: begin
               gamma_ff <= csr_wdata;
            end
            ltf_pkg::REG_NOISE_SCALE: begin
               noise_ff <= csr_wdata;
            end
            ltf_pkg::REG_HEAT_BOOST: begin
               boost_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // effective noise scale, boosted by sqrt(3) when heat boost is set
   always_comb begin
      boost_prod = {18'd0, noise_ff} * {33'd0, ltf_pkg::SQRT3_Q16} + 50'(ltf_pkg::HALF_Q16);
      scale_in   = boost_ff ? boost_prod[ltf_pkg::SCALE_W+15:16] : {1'b0, noise_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         scale_ff <= '0;
      end else begin
         scale_ff <= scale_in;
      end
   end

   // shared front end: gamma times mass, rounded to q16.16
   always_comb begin
      gm_prod = {32'd0, gamma_ff} * {32'd0, req_mass} + 64'(ltf_pkg::HALF_Q16);
      gm_in   = gm_prod[ltf_pkg::GM_W+15:16];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         gm_ff <= gm_in;
      end
   end

   // item valid flags along the pipeline
   assign vld_in = {vld_ff[ltf_pkg::PIPE_DEPTH-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= vld_in;
      end
   end

   // square root of mass
   ltf_isqrt u_isqrt (
      .clock (clock),
      .adv   (adv),
      .rad   ({req_mass, {ltf_pkg::FRAC_W{1'b0}}}),
      .root  (sm)
   );

   // one lane per axis
   ltf_lane u_lane_x (
      .clock    (clock),
      .adv      (adv),
      .vel      (req_vel_x),
      .force_in (req_force_x),
      .rnd      (req_rand_x),
      .gm       (gm_ff),
      .scale    (scale_ff),
      .sm       (sm),
      .sum      (sum_x)
   );

   ltf_lane u_lane_y (
      .clock    (clock),
      .adv      (adv),
      .vel      (req_vel_y),
      .force_in (req_force_y),
      .rnd      (req_rand_y),
      .gm       (gm_ff),
      .scale    (scale_ff),
      .sm       (sm),
      .sum      (sum_y)
   );

   ltf_lane u_lane_z (
      .clock    (clock),
      .adv      (adv),
      .vel      (req_vel_z),
      .force_in (req_force_z),
      .rnd      (req_rand_z),
      .gm       (gm_ff),
      .scale    (scale_ff),
      .sm       (sm),
      .sum      (sum_z)
   );

   // saturation and output buffering
   ltf_merge u_merge (
      .clock      (clock),
      .reset      (reset),
      .tail_valid (vld_ff[ltf_pkg::PIPE_DEPTH-1]),
      .sum_x      (sum_x),
      .sum_y      (sum_y),
      .sum_z      (sum_z),
      .rsp_stall  (rsp_stall),
      .rsp_valid  (rsp_valid),
      .rsp_data   (rsp_data),
      .pipe_hold  (pipe_hold)
   );

   assign rsp_new_force_x = rsp_data.x;
   assign rsp_new_force_y = rsp_data.y;
   assign rsp_new_force_z = rsp_data.z;

endmodule

@@ design/ltf_isqrt.sv @@
// pipelined floor square root of a 48-bit radicand, two result bits per stage
// depends on ltf_pkg
module ltf_isqrt (
   input  logic                       clock,
   input  logic                       adv,
   input  logic [ltf_pkg::RAD_W-1:0]  rad,
   output logic [ltf_pkg::ROOT_W-1:0] root
);

   typedef struct packed {
      logic [ltf_pkg::REM_W-1:0]  rem;
      logic [ltf_pkg::ROOT_W-1:0] root;
   } sqrt_state_type;

   // one restoring step: bring down two radicand bits, try to set the next root bit
   function automatic sqrt_state_type sqrt_step(sqrt_state_type st, logic [1:0] bits);
      logic [ltf_pkg::REM_W+1:0] acc;
      logic [ltf_pkg::REM_W+1:0] trial;
      sqrt_state_type            nx;
      acc   = {st.rem, bits};
      trial = (ltf_pkg::REM_W+2)'({st.root, 2'b01});
      if (acc >= trial) begin
         nx.rem  = ltf_pkg::REM_W'(acc - trial);
         nx.root = {st.root[ltf_pkg::ROOT_W-2:0], 1'b1};
      end else begin
         nx.rem  = ltf_pkg::REM_W'(acc);
         nx.root = {st.root[ltf_pkg::ROOT_W-2:0], 1'b0};
      end
      return nx;
   endfunction

   sqrt_state_type                st_ff  [0:ltf_pkg::SQRT_STAGES-1];
   sqrt_state_type                st_in  [0:ltf_pkg::SQRT_STAGES-1];
   sqrt_state_type                src_st [0:ltf_pkg::SQRT_STAGES-1];
   logic [ltf_pkg::RAD_W-1:0]     rad_ff [0:ltf_pkg::SQRT_STAGES-2];
   logic [ltf_pkg::RAD_W-1:0]     rad_in [0:ltf_pkg::SQRT_STAGES-2];
   logic [ltf_pkg::RAD_W-1:0]     src_rad[0:ltf_pkg::SQRT_STAGES-1];

   // stage inputs: first stage from the port, the rest from the previous stage
   always_comb begin
      src_st[0]  = '0;
      src_rad[0] = rad;
      for (int s = 1; s < ltf_pkg::SQRT_STAGES; s++) begin
         src_st[s]  = st_ff[s-1];
         src_rad[s] = rad_ff[s-1];
      end
   end

   // stage logic: two dependent steps on the top radicand bits
   always_comb begin
      for (int s = 0; s < ltf_pkg::SQRT_STAGES; s++) begin
         st_in[s] = src_st[s];
         for (int k = 0; k < ltf_pkg::SQRT_STEPS; k++) begin
            st_in[s] = sqrt_step(st_in[s], src_rad[s][ltf_pkg::RAD_W-1-2*k -: 2]);
         end
      end
      for (int s = 0; s < ltf_pkg::SQRT_STAGES-1; s++) begin
         rad_in[s] = src_rad[s] << (2 * ltf_pkg::SQRT_STEPS);
      end
   end

   // stage registers
   always_ff @(posedge clock) begin
      if (adv) begin
         for (int s = 0; s < ltf_pkg::SQRT_STAGES; s++) begin
            st_ff[s] <= st_in[s];
         end
         for (int s = 0; s < ltf_pkg::SQRT_STAGES-1; s++) begin
            rad_ff[s] <= rad_in[s];
         end
      end
   end

   assign root = st_ff[ltf_pkg::SQRT_STAGES-1].root;

endmodule

@@ design/ltf_lane.sv @@
// one axis lane: friction and noise terms added to the incoming force
// depends on ltf_pkg; takes gamma*mass and the mass root from the shared front end
module ltf_lane (
   input  logic                        clock,
   input  logic                        adv,
   input  logic [ltf_pkg::FIX_W-1:0]   vel,
   input  logic [ltf_pkg::FIX_W-1:0]   force_in,
   input  logic [ltf_pkg::RAND_W-1:0]  rnd,
   input  logic [ltf_pkg::GM_W-1:0]    gm,      // valid at stage 1
   input  logic [ltf_pkg::SCALE_W-1:0] scale,   // from configuration; user keeps it stable while busy (not enforced)
   input  logic [ltf_pkg::ROOT_W-1:0]  sm,      // valid at stage 12
   output logic [ltf_pkg::SUM_W-1:0]   sum
);

   typedef struct packed {
      logic [ltf_pkg::FIX_W-1:0] frc;
      logic [ltf_pkg::FR_W-1:0]  fr;
      logic                      cneg;
      logic [ltf_pkg::A_W-1:0]   a;
   } lane_hold_type;

   // stage 1: magnitudes and signs
   logic [ltf_pkg::FIX_W-1:0]  vmag1_ff, vmag1_in, frc1_ff, frc2_ff, frc13_ff;
   logic                       vneg1_ff, vneg1_in, vneg2_ff;
   logic                       cneg1_ff, cneg1_in, cneg2_ff, cneg13_ff;
   logic [ltf_pkg::CMAG_W-1:0] cmag1_ff, cmag1_in;
   // stage 2: partial products
   logic [47:0]                phi2_ff, phi2_in;
   logic [63:0]                plo2_ff, plo2_in;
   logic [ltf_pkg::A_W-1:0]    a2_ff, a2_in;
   logic [49:0]                a_prod;
   // stage 3 and delay line
   lane_hold_type              hold_ff [0:ltf_pkg::LANE_DELAY];
   lane_hold_type              hold_in;
   logic [63:0]                fmag;
   logic [48:0]                plo_rnd;
   logic [ltf_pkg::FRMAG_W-1:0] fmag_c;
   // stage 13: noise magnitude
   logic [57:0]                nz_prod;
   logic [ltf_pkg::NZ_W-1:0]   nz13_ff, nz13_in;
   logic [ltf_pkg::FR_W-1:0]   fr13_ff;
   // stage 14: exact sum
   logic [ltf_pkg::SUM_W-1:0]  sum14_ff, sum14_in, nz_ext;

   // stage 1: velocity and centered random as sign and magnitude
   always_comb begin
      vneg1_in = vel[ltf_pkg::FIX_W-1];
      vmag1_in = vel[ltf_pkg::FIX_W-1] ? (~vel + 1'b1) : vel;
      cneg1_in = ~rnd[ltf_pkg::RAND_W-1];
      cmag1_in = rnd[ltf_pkg::RAND_W-1] ? {1'b0, rnd[ltf_pkg::RAND_W-2:0]}
                                        : ltf_pkg::CMAG_W'(ltf_pkg::HALF_Q16 - {1'b0, rnd});
   end

   // stage 2: friction split into a 16x32 and a 32x32 partial product, noise prefactor
   always_comb begin
      phi2_in = gm[ltf_pkg::GM_W-1:32] * vmag1_ff;
      plo2_in = {32'd0, gm[31:0]} * {32'd0, vmag1_ff};
      a_prod  = {17'd0, scale} * {34'd0, cmag1_ff} + 50'(ltf_pkg::HALF_Q16);
      a2_in   = a_prod[ltf_pkg::A_W+15:16];
   end

   // stage 3: recombine, clamp, apply sign opposite to velocity
   always_comb begin
      plo_rnd = 49'(({1'b0, plo2_ff} + 65'(ltf_pkg::HALF_Q16)) >> 16);
      fmag    = {phi2_ff, 16'd0} + {15'd0, plo_rnd};
      if (fmag > ltf_pkg::FRICTION_LIMIT) begin
         fmag_c = ltf_pkg::FRMAG_W'(ltf_pkg::FRICTION_LIMIT);
      end else begin
         fmag_c = fmag[ltf_pkg::FRMAG_W-1:0];
      end
      hold_in.frc  = frc2_ff;
      hold_in.fr   = vneg2_ff ? {1'b0, fmag_c} : (~{1'b0, fmag_c} + 1'b1);
      hold_in.cneg = cneg2_ff;
      hold_in.a    = a2_ff;
   end

   // stage 13: noise magnitude from prefactor and mass root
   always_comb begin
      nz_prod = {25'd0, hold_ff[ltf_pkg::LANE_DELAY].a} * {34'd0, sm}
                + 58'(ltf_pkg::HALF_Q16);
      nz13_in = nz_prod[ltf_pkg::NZ_W+15:16];
   end

   // stage 14: force plus friction plus signed noise
   always_comb begin
      nz_ext   = {{(ltf_pkg::SUM_W-ltf_pkg::NZ_W){1'b0}}, nz13_ff};
      sum14_in = {{(ltf_pkg::SUM_W-ltf_pkg::FIX_W){frc13_ff[ltf_pkg::FIX_W-1]}}, frc13_ff}
               + {{(ltf_pkg::SUM_W-ltf_pkg::FR_W){fr13_ff[ltf_pkg::FR_W-1]}}, fr13_ff}
               + (cneg13_ff ? (~nz_ext + 1'b1) : nz_ext);
   end

   // lane registers, all moving together
   always_ff @(posedge clock) begin
      if (adv) begin
         vmag1_ff   <= vmag1_in;
         vneg1_ff   <= vneg1_in;
         cmag1_ff   <= cmag1_in;
         cneg1_ff   <= cneg1_in;
         frc1_ff    <= force_in;
         phi2_ff    <= phi2_in;
         plo2_ff    <= plo2_in;
         a2_ff      <= a2_in;
         vneg2_ff   <= vneg1_ff;
         cneg2_ff   <= cneg1_ff;
         frc2_ff    <= frc1_ff;
         hold_ff[0] <= hold_in;
         for (int k = 1; k <= ltf_pkg::LANE_DELAY; k++) begin
            hold_ff[k] <= hold_ff[k-1];
         end
         nz13_ff    <= nz13_in;
         fr13_ff    <= hold_ff[ltf_pkg::LANE_DELAY].fr;
         cneg13_ff  <= hold_ff[ltf_pkg::LANE_DELAY].cneg;
         frc13_ff   <= hold_ff[ltf_pkg::LANE_DELAY].frc;
         sum14_ff   <= sum14_in;
      end
   end

   assign sum = sum14_ff;

endmodule

@@ design/ltf_merge.sv @@
// merges the three lane sums into one saturated result with output and skid registers
// depends on ltf_pkg
module ltf_merge (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      tail_valid,
   input  logic [ltf_pkg::SUM_W-1:0] sum_x,
   input  logic [ltf_pkg::SUM_W-1:0] sum_y,
   input  logic [ltf_pkg::SUM_W-1:0] sum_z,
   input  logic                      rsp_stall,
   output logic                      rsp_valid,
   output ltf_pkg::force_vec_type    rsp_data,
   output logic                      pipe_hold
);

   // clamp an exact sum to the signed 32-bit range
   function automatic logic [ltf_pkg::FIX_W-1:0] sat_force(logic [ltf_pkg::SUM_W-1:0] s);
      logic [ltf_pkg::SUM_W-ltf_pkg::FIX_W:0] top;
      top = s[ltf_pkg::SUM_W-1:ltf_pkg::FIX_W-1];
      if (top == '0 || top == '1) begin
         return s[ltf_pkg::FIX_W-1:0];
      end else if (s[ltf_pkg::SUM_W-1]) begin
         return {1'b1, {(ltf_pkg::FIX_W-1){1'b0}}};
      end else begin
         return {1'b0, {(ltf_pkg::FIX_W-1){1'b1}}};
      end
   endfunction

   ltf_pkg::force_vec_type tail_in, out_ff, out_in, skid_ff, skid_in;
   logic                   out_valid_ff, out_valid_in, skid_valid_ff, skid_valid_in;
   logic                   out_take;

   // output register first, skid register when the output is stalled
   always_comb begin
      tail_in.x     = sat_force(sum_x);
      tail_in.y     = sat_force(sum_y);
      tail_in.z     = sat_force(sum_z);
      out_take      = out_valid_ff & ~rsp_stall;
      out_in        = out_ff;
      out_valid_in  = out_valid_ff;
      skid_in       = skid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         if (out_take) begin
            out_in        = skid_ff;
            out_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || out_take) begin
         out_in       = tail_in;
         out_valid_in = tail_valid;
      end else if (tail_valid) begin
         skid_in       = tail_in;
         skid_valid_in = 1'b1;
      end
   end

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;
   assign pipe_hold = skid_valid_ff;

endmodule

@@ design/ltf_checker.sv @@
// port-level checks for the langevin force block, bound to the top level
// depends on ltf_pkg and langevin_thermostat_force
module ltf_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      req_stall,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [ltf_pkg::FIX_W-1:0] rsp_new_force_x,
   input logic [ltf_pkg::FIX_W-1:0] rsp_new_force_y,
   input logic [ltf_pkg::FIX_W-1:0] rsp_new_force_z
);

   // reset empties the output and skid registers
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("output not empty after reset");

   // input is held back only while a result is waiting at the output
   a_stall_has_result: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   // the skid register fills only behind a stalled result
   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("input stall without output back-pressure");

   // a stalled result keeps its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_new_force_x)
         && $stable(rsp_new_force_y) && $stable(rsp_new_force_z))
      else $error("stalled result changed");

endmodule

bind langevin_thermostat_force ltf_checker u_ltf_checker (
   .clock           (clock),
   .reset           (reset),
   .req_stall       (req_stall),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_new_force_x (rsp_new_force_x),
   .rsp_new_force_y (rsp_new_force_y),
   .rsp_new_force_z (rsp_new_force_z)
);

@@ bench/tb_top.sv @@
// self-checking bench for langevin_thermostat_force: directed and random particles
// with a bit-exact force predictor, random sender gaps and random receiver stalls
// depends on ltf_pkg and the langevin_thermostat_force rtl
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   // register index that maps to no register
   localparam logic [ltf_pkg::CSR_IDX_W-1:0] REG_UNUSED_IDX = 2'd3;
   // receiver hold-off length in cycles
   localparam int LONG_HOLD = 80;
   localparam int RANDOM_PHASES = 8;
   localparam int PHASE_ITEMS = 60;
   localparam longint SAT_HI = 64'sd2147483647;
   localparam longint SAT_LO = -64'sd2147483648;

   typedef struct packed {
      logic [ltf_pkg::FIX_W-1:0]  mass;
      logic [ltf_pkg::FIX_W-1:0]  vel_x;
      logic [ltf_pkg::FIX_W-1:0]  vel_y;
      logic [ltf_pkg::FIX_W-1:0]  vel_z;
      logic [ltf_pkg::FIX_W-1:0]  force_x;
      logic [ltf_pkg::FIX_W-1:0]  force_y;
      logic [ltf_pkg::FIX_W-1:0]  force_z;
      logic [ltf_pkg::RAND_W-1:0] rand_x;
      logic [ltf_pkg::RAND_W-1:0] rand_y;
      logic [ltf_pkg::RAND_W-1:0] rand_z;
   } particle_type;

   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_wr_en = 1'b0;
   logic [ltf_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [ltf_pkg::FIX_W-1:0]     csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_stall;
   logic [ltf_pkg::FIX_W-1:0]     req_mass = '0;
   logic [ltf_pkg::FIX_W-1:0]     req_vel_x = '0;
   logic [ltf_pkg::FIX_W-1:0]     req_vel_y = '0;
   logic [ltf_pkg::FIX_W-1:0]     req_vel_z = '0;
   logic [ltf_pkg::FIX_W-1:0]     req_force_x = '0;
   logic [ltf_pkg::FIX_W-1:0]     req_force_y = '0;
   logic [ltf_pkg::FIX_W-1:0]     req_force_z = '0;
   logic [ltf_pkg::RAND_W-1:0]    req_rand_x = '0;
   logic [ltf_pkg::RAND_W-1:0]    req_rand_y = '0;
   logic [ltf_pkg::RAND_W-1:0]    req_rand_z = '0;
   logic                          rsp_valid;
   logic                          rsp_stall = 1'b0;
   logic [ltf_pkg::FIX_W-1:0]     rsp_new_force_x;
   logic [ltf_pkg::FIX_W-1:0]     rsp_new_force_y;
   logic [ltf_pkg::FIX_W-1:0]     rsp_new_force_z;

   // shadow copy of the configuration registers
   logic [ltf_pkg::FIX_W-1:0]     gamma_shadow = '0;
   logic [ltf_pkg::FIX_W-1:0]     noise_shadow = '0;
   logic                          boost_shadow = 1'b0;

   ltf_pkg::force_vec_type        pending_forces[$];
   ltf_pkg::force_vec_type        want_force;
   int                            mismatches = 0;
   bit                            steady = 1'b0;
   int                            hold_asked = 0;
   int                            hold_seen = 0;
   int                            hold_left = 0;

   langevin_thermostat_force dut (
      .clock           (clock),
      .reset           (reset),
      .csr_wr_en       (csr_wr_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_mass        (req_mass),
      .req_vel_x       (req_vel_x),
      .req_vel_y       (req_vel_y),
      .req_vel_z       (req_vel_z),
      .req_force_x     (req_force_x),
      .req_force_y     (req_force_y),
      .req_force_z     (req_force_z),
      .req_rand_x      (req_rand_x),
      .req_rand_y      (req_rand_y),
      .req_rand_z      (req_rand_z),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_new_force_x (rsp_new_force_x),
      .rsp_new_force_y (rsp_new_force_y),
      .rsp_new_force_z (rsp_new_force_z)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // one axis: incoming force plus friction plus noise, saturated
   function automatic logic [ltf_pkg::FIX_W-1:0] axis_force(logic [63:0] gm, logic [63:0] s,
                                                   logic [23:0] root,
                                                   logic [ltf_pkg::FIX_W-1:0] v,
                                                   logic [ltf_pkg::FIX_W-1:0] f,
                                                   logic [ltf_pkg::RAND_W-1:0] r);
      logic [ltf_pkg::FIX_W-1:0] mag_v;
      logic [95:0]      fr_mag;
      logic [16:0]      mag_c;
      logic [63:0]      a;
      logic [63:0]      nz_mag;
      longint           fr;
      longint           nz;
      longint           sum;
      mag_v = v[31] ? (~v + 32'd1) : v;
      fr_mag = (96'(gm) * 96'(mag_v) + 96'(ltf_pkg::HALF_Q16)) >> ltf_pkg::FRAC_W;
      if (fr_mag > 96'(ltf_pkg::FRICTION_LIMIT))
         fr_mag = 96'(ltf_pkg::FRICTION_LIMIT);
      // friction opposes the velocity
      fr = v[31] ? longint'(fr_mag[63:0]) : -longint'(fr_mag[63:0]);
      // centered random, negative below one half
      mag_c = r[15] ? {2'b00, r[14:0]} : (17'd32768 - {1'b0, r});
      a = (s * 64'(mag_c) + 64'(ltf_pkg::HALF_Q16)) >> ltf_pkg::FRAC_W;
      nz_mag = (a * 64'(root) + 64'(ltf_pkg::HALF_Q16)) >> ltf_pkg::FRAC_W;
      nz = r[15] ? longint'(nz_mag) : -longint'(nz_mag);
      sum = longint'($signed(f)) + fr + nz;
      if (sum > SAT_HI)
         return 32'h7FFF_FFFF;
      else if (sum < SAT_LO)
         return 32'h8000_0000;
      return sum[31:0];
   endfunction

   // expected new forces for one particle under the shadow configuration
   function automatic ltf_pkg::force_vec_type langevin_force(particle_type p);
      logic [63:0]            gm;
      logic [63:0]            s;
      logic [47:0]            rad;
      logic [23:0]            root;
      logic [23:0]            trial;
      ltf_pkg::force_vec_type res;
      gm = (64'(gamma_shadow) * 64'(p.mass) + 64'(ltf_pkg::HALF_Q16)) >> ltf_pkg::FRAC_W;
      s = 64'(noise_shadow);
      if (boost_shadow)
         s = (64'(noise_shadow) * 64'(ltf_pkg::SQRT3_Q16) + 64'(ltf_pkg::HALF_Q16))
             >> ltf_pkg::FRAC_W;
      // floor square root of mass in q16.16, one bit at a time
      rad = {p.mass, 16'h0000};
      root = '0;
      for (int i = 23; i >= 0; i--) begin
         trial = root | (24'd1 << i);
         if (48'(trial) * 48'(trial) <= rad)
            root = trial;
      end
      res.x = axis_force(gm, s, root, p.vel_x, p.force_x, p.rand_x);
      res.y = axis_force(gm, s, root, p.vel_y, p.force_y, p.rand_y);
      res.z = axis_force(gm, s, root, p.vel_z, p.force_z, p.rand_z);
      return res;
   endfunction

   function automatic particle_type make_particle(logic [31:0] m, logic [31:0] vx,
                                               logic [31:0] vy, logic [31:0] vz,
                                               logic [31:0] fx, logic [31:0] fy,
                                               logic [31:0] fz, logic [15:0] rx,
                                               logic [15:0] ry, logic [15:0] rz);
      particle_type p;
      p = '{m, vx, vy, vz, fx, fy, fz, rx, ry, rz};
      return p;
   endfunction

   // signed q16.16 value: full range, small magnitude or an extreme
   function automatic logic [31:0] random_fix();
      int unsigned pick;
      pick = $urandom_range(9);
      if (pick < 5)
         return $urandom();
      else if (pick < 8)
         return 32'($signed($urandom_range(2097152)) - 1048576);
      case ($urandom_range(4))
         0: return 32'h8000_0000;
         1: return 32'h7FFF_FFFF;
         2: return 32'h0000_0000;
         3: return 32'h0000_0001;
         default: return 32'hFFFF_FFFF;
      endcase
   endfunction

   function automatic logic [15:0] random_frac();
      if ($urandom_range(9) < 8)
         return 16'($urandom());
      case ($urandom_range(3))
         0: return 16'h0000;
         1: return 16'h7FFF;
         2: return 16'h8000;
         default: return 16'hFFFF;
      endcase
   endfunction

   // unsigned register or mass value: full range, physically small or an extreme
   function automatic logic [31:0] random_unsigned();
      case ($urandom_range(9))
         0, 1, 2, 3: return $urandom();
         4, 5, 6: return $urandom_range(32'h0040_0000, 32'h0000_1000);
         7: return 32'h0000_0000;
         8: return 32'hFFFF_FFFF;
         default: return $urandom_range(255);
      endcase
   endfunction

   function automatic particle_type random_particle();
      particle_type p;
      p = make_particle(random_unsigned(), random_fix(), random_fix(), random_fix(),
                        random_fix(), random_fix(), random_fix(),
                        random_frac(), random_frac(), random_frac());
      return p;
   endfunction

   // register write, mirrored into the shadow copy
   task automatic write_csr(input logic [ltf_pkg::CSR_IDX_W-1:0] idx,
                            input logic [ltf_pkg::FIX_W-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      case (idx)
         ltf_pkg::REG_FRICTION_GAMMA: gamma_shadow = data;
         ltf_pkg::REG_NOISE_SCALE:    noise_shadow = data;
         ltf_pkg::REG_HEAT_BOOST:     boost_shadow = data[0];
         default: ;
      endcase
   endtask

   // offer one particle, with an occasional gap before it, until transferred
   task automatic send_particle(input particle_type p);
      if (!steady && $urandom_range(99) < 20) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(3, 1)) @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_mass    <= p.mass;
      req_vel_x   <= p.vel_x;
      req_vel_y   <= p.vel_y;
      req_vel_z   <= p.vel_z;
      req_force_x <= p.force_x;
      req_force_y <= p.force_y;
      req_force_z <= p.force_z;
      req_rand_x  <= p.rand_x;
      req_rand_y  <= p.rand_y;
      req_rand_z  <= p.rand_z;
      do @(posedge clock); while (req_stall);
      pending_forces.push_back(langevin_force(p));
   endtask

   task automatic idle_sender();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic wait_drained();
      while (pending_forces.size() != 0)
         @(posedge clock);
   endtask

   // registers at reset value: forces pass through untouched
   task automatic test_reset_defaults();
      send_particle(make_particle(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1234_5678,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000,
                                  16'h0000, 16'hFFFF, 16'h8000));
      send_particle(make_particle(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                                  32'hDEAD_BEEF, 32'h0000_0001, 32'hFFFF_FFFF,
                                  16'h7FFF, 16'h8001, 16'h1234));
      idle_sender();
      wait_drained();
   endtask

   // field extremes with the largest gamma and noise scale, boosted and not, then the smallest nonzero settings
   task automatic test_field_extremes();
      write_csr(ltf_pkg::REG_FRICTION_GAMMA, 32'hFFFF_FFFF);
      write_csr(ltf_pkg::REG_NOISE_SCALE, 32'hFFFF_FFFF);
      write_csr(ltf_pkg::REG_HEAT_BOOST, 32'h1);
      // zero mass: force unchanged
      send_particle(make_particle(32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h1,
                                  32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                  16'h0000, 16'hFFFF, 16'h8000));
      // heavy particle: friction clamp and saturation both ways
      send_particle(make_particle(32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0,
                                  32'h0, 32'h0, 32'h0, 16'h8000, 16'h8000, 16'h8000));
      send_particle(make_particle(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                  32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                  16'hFFFF, 16'h0000, 16'h7FFF));
      send_particle(make_particle(32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001, 32'h8000_0000,
                                  32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                  16'h0001, 16'hFFFE, 16'h8001));
      send_particle(make_particle(32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000,
                                  32'h0, 32'h0, 32'h0, 16'h0000, 16'hFFFF, 16'h4000));
      idle_sender();
      wait_drained();
      write_csr(ltf_pkg::REG_HEAT_BOOST, 32'h0);
      send_particle(make_particle(32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0,
                                  32'h0, 32'h0, 32'h0, 16'h0000, 16'hFFFF, 16'h8000));
      send_particle(make_particle(32'h0004_0000, 32'h0000_0100, 32'hFFFF_FF00, 32'h0,
                                  32'h0010_0000, 32'hFFF0_0000, 32'h0,
                                  16'h0000, 16'hFFFF, 16'hC000));
      idle_sender();
      wait_drained();
      // small settings: rounding near zero
      write_csr(ltf_pkg::REG_FRICTION_GAMMA, 32'h0000_0001);
      write_csr(ltf_pkg::REG_NOISE_SCALE, 32'h0000_0001);
      send_particle(make_particle(32'h0000_8000, 32'h0000_8000, 32'hFFFF_8000, 32'h0001_0000,
                                  32'h0, 32'h0, 32'h0, 16'h0000, 16'hFFFF, 16'h7FFF));
      send_particle(make_particle(32'h0001_8000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0,
                                  32'h0, 32'h0, 32'h0, 16'h4000, 16'hC000, 16'h8000));
      idle_sender();
      wait_drained();
   endtask

   // index out of range is ignored, boost keeps bit 0 only
   task automatic test_register_masking();
      write_csr(ltf_pkg::REG_FRICTION_GAMMA, 32'h0002_0000);
      write_csr(ltf_pkg::REG_NOISE_SCALE, 32'h0010_0000);
      write_csr(REG_UNUSED_IDX, 32'hFFFF_FFFF);
      write_csr(ltf_pkg::REG_HEAT_BOOST, 32'hFFFF_FFFE);
      send_particle(make_particle(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                                  32'h0, 32'h0, 32'h0, 16'h0000, 16'hFFFF, 16'h8000));
      idle_sender();
      wait_drained();
      write_csr(ltf_pkg::REG_HEAT_BOOST, 32'h0000_0003);
      send_particle(make_particle(32'h0002_0000, 32'h0001_0000, 32'hFFFF_0000, 32'h0,
                                  32'h0, 32'h0, 32'h0, 16'h0000, 16'hFFFF, 16'h8000));
      idle_sender();
      wait_drained();
      write_csr(REG_UNUSED_IDX, 32'h0000_0000);
      send_particle(make_particle(32'h0003_0000, 32'h0000_4000, 32'h0, 32'hFFFF_C000,
                                  32'h0, 32'h0, 32'h0, 16'h2000, 16'hE000, 16'h8000));
      idle_sender();
      wait_drained();
   endtask

   // random particles over several register settings, extremes among them
   task automatic test_random_sweep();
      for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
         wait_drained();
         case (phase)
            0: begin
               write_csr(ltf_pkg::REG_FRICTION_GAMMA, 32'h0);
               write_csr(ltf_pkg::REG_NOISE_SCALE, 32'h0);
               write_csr(ltf_pkg::REG_HEAT_BOOST, 32'h0);
            end
            1: begin
               write_csr(ltf_pkg::REG_FRICTION_GAMMA, 32'hFFFF_FFFF);
               write_csr(ltf_pkg::REG_NOISE_SCALE, 32'hFFFF_FFFF);
               write_csr(ltf_pkg::REG_HEAT_BOOST, 32'h1);
            end
            default: begin
               write_csr(ltf_pkg::REG_FRICTION_GAMMA, random_unsigned());
               write_csr(ltf_pkg::REG_NOISE_SCALE, random_unsigned());
               write_csr(ltf_pkg::REG_HEAT_BOOST, $urandom());
            end
         endcase
         // one phase runs with no idling on either side
         steady = (phase == 3);
         for (int n = 0; n < PHASE_ITEMS; n++)
            send_particle(random_particle());
         idle_sender();
         steady = 1'b0;
      end
      wait_drained();
   endtask

   // receiver holds off while the sender streams, filling the pipeline
   task automatic test_output_hold();
      steady = 1'b1;
      hold_asked++;
      for (int n = 0; n < 40; n++)
         send_particle(random_particle());
      idle_sender();
      steady = 1'b0;
      wait_drained();
   endtask

   // sender pauses until every result has come back, then resumes
   task automatic test_pause_for_drain();
      for (int n = 0; n < 10; n++)
         send_particle(random_particle());
      idle_sender();
      wait_drained();
      for (int n = 0; n < 10; n++)
         send_particle(random_particle());
      idle_sender();
      wait_drained();
   endtask

   // receiver stall: long hold-off on request, random otherwise
   always @(posedge clock) begin
      if (hold_seen != hold_asked) begin
         hold_seen = hold_asked;
         hold_left = LONG_HOLD;
      end
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left = hold_left - 1;
      end else begin
         rsp_stall <= !steady && ($urandom_range(99) < 20);
      end
   end

   // compare each result transfer with the oldest expected forces
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_forces.size() == 0) begin
            $error("force result with none expected: %h %h %h",
                   rsp_new_force_x, rsp_new_force_y, rsp_new_force_z);
            mismatches++;
         end else begin
            want_force = pending_forces.pop_front();
            if (rsp_new_force_x !== want_force.x) begin
               $error("new_force_x: expected %h, actual %h", want_force.x, rsp_new_force_x);
               mismatches++;
            end
            if (rsp_new_force_y !== want_force.y) begin
               $error("new_force_y: expected %h, actual %h", want_force.y, rsp_new_force_y);
               mismatches++;
            end
            if (rsp_new_force_z !== want_force.z) begin
               $error("new_force_z: expected %h, actual %h", want_force.z, rsp_new_force_z);
               mismatches++;
            end
         end
      end
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reset_defaults();
      test_field_extremes();
      test_register_masking();
      test_output_hold();
      test_pause_for_drain();
      test_random_sweep();
      test_output_hold();
      wait_drained();
      // let any stray result show up
      repeat (ltf_pkg::PIPE_DEPTH + 20) @(posedge clock);
      if (mismatches == 0 && pending_forces.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // run limit
   initial begin
      #5_000_000;
      $display("end of test: mismatches");
      $finish;
   end

endmodule

@@ files.f @@
design/ltf_pkg.sv
design/ltf_isqrt.sv
design/ltf_lane.sv
design/ltf_merge.sv
design/langevin_thermostat_force.sv
design/ltf_checker.sv
bench/tb_top.sv
